// ===== design/qrm_pkg.sv =====
// ----------------------------------------------------------------------------
// qrm_pkg
// Shared types and fixed widths for the quaternion to rotation matrix block.
// ----------------------------------------------------------------------------
package qrm_pkg;

  // field and datapath widths fixed by the interface
  localparam int IN_W      = 16;
  localparam int ELEM_W    = 16;
  localparam int NUM_ELEMS = 9;
  localparam int PROD_W    = 32;   // 16x16 signed product
  localparam int SUM_W     = 34;   // signed numerator / remainder width
  localparam int DEN_W     = 33;   // squared norm, unsigned

  // input request: one quaternion
  typedef struct packed {
    logic signed [IN_W-1:0] quat_w;
    logic signed [IN_W-1:0] quat_x;
    logic signed [IN_W-1:0] quat_y;
    logic signed [IN_W-1:0] quat_z;
  } quat_in_t;

  // output request: one 3x3 matrix plus zero flag
  typedef struct packed {
    logic signed [ELEM_W-1:0] elem_00;
    logic signed [ELEM_W-1:0] elem_01;
    logic signed [ELEM_W-1:0] elem_02;
    logic signed [ELEM_W-1:0] elem_10;
    logic signed [ELEM_W-1:0] elem_11;
    logic signed [ELEM_W-1:0] elem_12;
    logic signed [ELEM_W-1:0] elem_20;
    logic signed [ELEM_W-1:0] elem_21;
    logic signed [ELEM_W-1:0] elem_22;
    logic                     zero_norm;
  } rot_out_t;

endpackage

// ===== design/quaternion_to_rotation_matrix.sv =====
// Throughput: one quaternion per cycle; a nine-lane restoring divider with one
// quotient bit per stage (FRAC_BITS + 2 stages) sets the depth.
// A stall at the output freezes the whole pipeline; nothing is dropped.
// Reset (rst_n low, synchronous) clears the valid bits only.
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// Converts a quaternion to its 3x3 rotation matrix, normalized by the squared
// norm, rounded to nearest (ties away from zero) and saturated to +-1.0.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix #(
  parameter int FRAC_BITS = 14
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  qrm_pkg::quat_in_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output qrm_pkg::rot_out_t out_data
);
  import qrm_pkg::*;

  localparam int QW = FRAC_BITS + 2;                    // quotient bits incl. half bit
  localparam int RW = (QW + 1 > ELEM_W) ? QW + 1 : ELEM_W;
  localparam logic [QW-1:0] QLIM = {2'b01, {FRAC_BITS{1'b0}}};
  localparam int ELIM = (FRAC_BITS <= 14) ? (1 << FRAC_BITS) : 0;

  logic adv;

  // global advance: move when the output slot is free or being taken
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // --------------------------------------------------------------------------
  // Stage 1: products
  // --------------------------------------------------------------------------
  logic                     s1_vld_r;
  logic                     s1_zero_r;
  logic signed [PROD_W-1:0] s1_sw_r, s1_sx_r, s1_sy_r, s1_sz_r;
  logic signed [PROD_W-1:0] s1_xy_r, s1_zw_r, s1_xz_r, s1_yw_r, s1_yz_r, s1_xw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_zero_r <= (in_data.quat_w == '0) && (in_data.quat_x == '0) &&
                   (in_data.quat_y == '0) && (in_data.quat_z == '0);
      s1_sw_r   <= in_data.quat_w * in_data.quat_w;
      s1_sx_r   <= in_data.quat_x * in_data.quat_x;
      s1_sy_r   <= in_data.quat_y * in_data.quat_y;
      s1_sz_r   <= in_data.quat_z * in_data.quat_z;
      s1_xy_r   <= in_data.quat_x * in_data.quat_y;
      s1_zw_r   <= in_data.quat_z * in_data.quat_w;
      s1_xz_r   <= in_data.quat_x * in_data.quat_z;
      s1_yw_r   <= in_data.quat_y * in_data.quat_w;
      s1_yz_r   <= in_data.quat_y * in_data.quat_z;
      s1_xw_r   <= in_data.quat_x * in_data.quat_w;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: numerators and squared norm
  // --------------------------------------------------------------------------
  logic                    s2_vld_r;
  logic                    s2_zero_r;
  logic signed [SUM_W-1:0] s2_num_r [NUM_ELEMS];
  logic        [DEN_W-1:0] s2_den_r;

  logic signed [SUM_W-1:0] e_sw, e_sx, e_sy, e_sz;
  logic signed [SUM_W-1:0] e_xy, e_zw, e_xz, e_yw, e_yz, e_xw;

  always_comb begin
    e_sw = SUM_W'(s1_sw_r);
    e_sx = SUM_W'(s1_sx_r);
    e_sy = SUM_W'(s1_sy_r);
    e_sz = SUM_W'(s1_sz_r);
    e_xy = SUM_W'(s1_xy_r);
    e_zw = SUM_W'(s1_zw_r);
    e_xz = SUM_W'(s1_xz_r);
    e_yw = SUM_W'(s1_yw_r);
    e_yz = SUM_W'(s1_yz_r);
    e_xw = SUM_W'(s1_xw_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_zero_r   <= s1_zero_r;
      // squares are nonnegative and below 2^31
      s2_den_r    <= {2'b00, s1_sw_r[PROD_W-2:0]} + {2'b00, s1_sx_r[PROD_W-2:0]} +
                     {2'b00, s1_sy_r[PROD_W-2:0]} + {2'b00, s1_sz_r[PROD_W-2:0]};
      s2_num_r[0] <= e_sx - e_sy - e_sz + e_sw;
      s2_num_r[1] <= (e_xy - e_zw) <<< 1;
      s2_num_r[2] <= (e_xz + e_yw) <<< 1;
      s2_num_r[3] <= (e_xy + e_zw) <<< 1;
      s2_num_r[4] <= e_sy - e_sx - e_sz + e_sw;
      s2_num_r[5] <= (e_yz - e_xw) <<< 1;
      s2_num_r[6] <= (e_xz - e_yw) <<< 1;
      s2_num_r[7] <= (e_yz + e_xw) <<< 1;
      s2_num_r[8] <= e_sz - e_sx - e_sy + e_sw;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: sign, magnitude, clamp magnitude to the norm
  // --------------------------------------------------------------------------
  logic                   s3_vld_r;
  logic                   s3_zero_r;
  logic [NUM_ELEMS-1:0]   s3_neg_r;
  logic [SUM_W-1:0]       s3_mag_r [NUM_ELEMS];
  logic [DEN_W-1:0]       s3_den_r;

  logic [SUM_W-1:0]       abs_val [NUM_ELEMS];

  always_comb begin
    for (int k = 0; k < NUM_ELEMS; k++) begin
      abs_val[k] = s2_num_r[k][SUM_W-1] ? SUM_W'(-s2_num_r[k]) : SUM_W'(s2_num_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_zero_r <= s2_zero_r;
      s3_den_r  <= s2_den_r;
      for (int k = 0; k < NUM_ELEMS; k++) begin
        s3_neg_r[k] <= s2_num_r[k][SUM_W-1];
        s3_mag_r[k] <= (abs_val[k] > {1'b0, s2_den_r}) ? {1'b0, s2_den_r} : abs_val[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Divider: one restoring quotient bit per stage, nine lanes in parallel
  // --------------------------------------------------------------------------
  logic [QW-1:0]        div_vld_r;
  logic [QW-1:0]        div_zero_r;
  logic [NUM_ELEMS-1:0] div_neg_r [QW];
  logic [DEN_W-1:0]     div_den_r [QW];
  logic [SUM_W-1:0]     div_rem_r [QW][NUM_ELEMS];
  logic [QW-1:0]        div_quo_r [QW][NUM_ELEMS];

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic                 prv_vld;
    logic                 prv_zero;
    logic [NUM_ELEMS-1:0] prv_neg;
    logic [DEN_W-1:0]     prv_den;
    logic [SUM_W-1:0]     prv_rem [NUM_ELEMS];
    logic [QW-1:0]        prv_quo [NUM_ELEMS];
    logic [SUM_W-1:0]     trial   [NUM_ELEMS];
    logic [NUM_ELEMS-1:0] qbit;

    if (j == 0) begin : g_first
      // first bit: no shift, the magnitude never exceeds the norm
      always_comb begin
        prv_vld  = s3_vld_r;
        prv_zero = s3_zero_r;
        prv_neg  = s3_neg_r;
        prv_den  = s3_den_r;
        for (int k = 0; k < NUM_ELEMS; k++) begin
          prv_rem[k] = s3_mag_r[k];
          prv_quo[k] = '0;
          trial[k]   = prv_rem[k];
        end
      end
    end else begin : g_next
      always_comb begin
        prv_vld  = div_vld_r[j-1];
        prv_zero = div_zero_r[j-1];
        prv_neg  = div_neg_r[j-1];
        prv_den  = div_den_r[j-1];
        for (int k = 0; k < NUM_ELEMS; k++) begin
          prv_rem[k] = div_rem_r[j-1][k];
          prv_quo[k] = div_quo_r[j-1][k];
          trial[k]   = {prv_rem[k][SUM_W-2:0], 1'b0};
        end
      end
    end

    // compare against the norm
    always_comb begin
      for (int k = 0; k < NUM_ELEMS; k++) begin
        qbit[k] = (trial[k] >= {1'b0, prv_den});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_vld_r[j] <= 1'b0;
      end else if (adv) begin
        div_vld_r[j] <= prv_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        div_zero_r[j] <= prv_zero;
        div_neg_r[j]  <= prv_neg;
        div_den_r[j]  <= prv_den;
        for (int k = 0; k < NUM_ELEMS; k++) begin
          div_rem_r[j][k] <= qbit[k] ? (trial[k] - {1'b0, prv_den}) : trial[k];
          div_quo_r[j][k] <= {prv_quo[k][QW-2:0], qbit[k]};
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: round half up on the magnitude, saturate, restore sign
  // --------------------------------------------------------------------------
  logic                out_vld_r;
  logic                out_zero_r;
  logic [ELEM_W-1:0]   out_elem_r [NUM_ELEMS];

  logic [QW:0]         q_inc [NUM_ELEMS];
  logic [QW-1:0]       q_rnd [NUM_ELEMS];
  logic signed [RW-1:0] q_sgn [NUM_ELEMS];

  always_comb begin
    for (int k = 0; k < NUM_ELEMS; k++) begin
      q_inc[k] = {1'b0, div_quo_r[QW-1][k]} + (QW+1)'(1);
      q_rnd[k] = (q_inc[k][QW:1] > QLIM) ? QLIM : q_inc[k][QW:1];
      q_sgn[k] = RW'(q_rnd[k]);
      if (div_zero_r[QW-1]) begin
        q_sgn[k] = '0;
      end else if (div_neg_r[QW-1][k]) begin
        q_sgn[k] = -q_sgn[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= div_vld_r[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_zero_r <= div_zero_r[QW-1];
      for (int k = 0; k < NUM_ELEMS; k++) begin
        out_elem_r[k] <= q_sgn[k][ELEM_W-1:0];
      end
    end
  end

  // output mapping
  assign out_valid          = out_vld_r;
  assign out_data.elem_00   = out_elem_r[0];
  assign out_data.elem_01   = out_elem_r[1];
  assign out_data.elem_02   = out_elem_r[2];
  assign out_data.elem_10   = out_elem_r[3];
  assign out_data.elem_11   = out_elem_r[4];
  assign out_data.elem_12   = out_elem_r[5];
  assign out_data.elem_20   = out_elem_r[6];
  assign out_data.elem_21   = out_elem_r[7];
  assign out_data.elem_22   = out_elem_r[8];
  assign out_data.zero_norm = out_zero_r;

`ifndef SYNTHESIS
  // zero quaternion gives an all-zero matrix
  a_zero_matrix: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_norm |->
      out_data.elem_00 == '0 && out_data.elem_01 == '0 && out_data.elem_02 == '0 &&
      out_data.elem_10 == '0 && out_data.elem_11 == '0 && out_data.elem_12 == '0 &&
      out_data.elem_20 == '0 && out_data.elem_21 == '0 && out_data.elem_22 == '0)
    else $error("zero_norm set with nonzero matrix element");

  // saturated range holds for elem_00 and elem_11 whenever +-1.0 fits the field
  a_elem_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (FRAC_BITS > 14) ||
      ($signed(out_data.elem_00) <= ELIM && $signed(out_data.elem_00) >= -ELIM &&
       $signed(out_data.elem_11) <= ELIM && $signed(out_data.elem_11) >= -ELIM))
    else $error("matrix element outside +-1.0");

  // divider remainder of lane 0 stays below the norm
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    div_vld_r[QW-1] && !div_zero_r[QW-1] |->
      div_rem_r[QW-1][0] < {1'b0, div_den_r[QW-1]})
    else $error("divider remainder not below norm");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule
